// ----- rtl/core/pspp_pkg.sv -----
// Package for the pressure series packet parser core.
// Holds the channel payload types, the record type passed between stages,
// header offsets and register indexes. No dependencies.
`default_nettype none

package pspp_pkg;

    // Packet layout
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned OFFSET_W     = 12;
    localparam logic [OFFSET_W-1:0] FIRST_RECORD_BYTE = 12'd10;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX        = 12'd4095;

    // Header byte offsets
    localparam logic [OFFSET_W-1:0] HDR_ID       = 12'd0;
    localparam logic [OFFSET_W-1:0] HDR_VER_LEN  = 12'd1;
    localparam logic [OFFSET_W-1:0] HDR_LEN_LO   = 12'd2;
    localparam logic [OFFSET_W-1:0] HDR_TIME_B3  = 12'd6;
    localparam logic [OFFSET_W-1:0] HDR_TIME_B2  = 12'd7;
    localparam logic [OFFSET_W-1:0] HDR_TIME_B1  = 12'd8;
    localparam logic [OFFSET_W-1:0] HDR_TIME_B0  = 12'd9;

    // Format version that carries a three-byte time count
    localparam logic [3:0] VERSION_LONG_TIME = 4'd1;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET = 2'd1;

    // Input transaction
    typedef struct packed {
        logic [BYTE_W-1:0] packet_byte;
        logic              last_byte;
    } in_t;

    // Record handed from the parser to the scaling stage
    typedef struct packed {
        logic                status;
        logic [32:0]         time_seconds;
        logic [3:0]          phase;
        logic [19:0]         pressure_count;
        logic [OFFSET_W-1:0] record_offset;
        logic [3:0]          packet_number;
        logic [3:0]          format_version;
        logic                unknown_version;
    } rec_t;

    // Output transaction
    typedef struct packed {
        logic                status;
        logic [32:0]         time_seconds;
        logic [3:0]          phase;
        logic [19:0]         pressure_count;
        logic signed [47:0]  pressure_dbar;
        logic [OFFSET_W-1:0] record_offset;
        logic [3:0]          packet_number;
        logic [3:0]          format_version;
        logic                unknown_version;
    } out_t;

endpackage

`default_nettype wire

// ----- rtl/core/pressure_series_packet_parser_core.sv -----
// Pressure series packet parser, top level: configuration registers,
// record stage and pressure scaling stage. Depends on pspp_pkg and pspp_parser.
//
// Accepts one packet byte per cycle with no gaps while in_stall is low. A record
// result for the byte that completes it (or the packet's last byte, for a
// truncated record) passes through the record register and then the scaling
// register that holds the 20x32 multiply and offset subtract. Both output-side
// stages hold under out_stall and pass stall back to the input only when both are full.
// Write the gain and offset registers only while no bytes are in flight.
`default_nettype none

module pressure_series_packet_parser_core
    import pspp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_t                    in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_t                        out_data
);

    logic [31:0]        count_gain_reg;
    logic signed [31:0] dbar_offset_reg;

    logic  in_accept;
    logic  s2_take;
    logic  rec_valid;
    rec_t  rec;

    logic  s1_valid_reg;
    rec_t  s1_rec_reg;
    logic  out_valid_reg;
    out_t  out_data_reg;

    logic [51:0] product;
    logic [43:0] scaled;
    logic signed [47:0] dbar;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_gain_reg  <= '0;
            dbar_offset_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GAIN:   count_gain_reg  <= cfg_data;
                CFG_OFFSET: dbar_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: advance the pipe whenever the output slot frees up
    assign s2_take   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !s2_take;
    assign in_accept = in_valid && !in_stall;

    pspp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .in_data   (in_data),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // Record register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || s2_take)
        begin
            s1_valid_reg <= rec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_valid)
        begin
            s1_rec_reg <= rec;
        end
    end

    // Scale: count * gain, drop 8 fraction bits, subtract offset
    assign product = {32'd0, s1_rec_reg.pressure_count} * {20'd0, count_gain_reg};
    assign scaled  = product[51:8];
    assign dbar    = signed'({4'd0, scaled}) - 48'(dbar_offset_reg);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_take)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take && s1_valid_reg)
        begin
            out_data_reg.status          <= s1_rec_reg.status;
            out_data_reg.time_seconds    <= s1_rec_reg.time_seconds;
            out_data_reg.phase           <= s1_rec_reg.phase;
            out_data_reg.pressure_count  <= s1_rec_reg.pressure_count;
            out_data_reg.pressure_dbar   <= dbar;
            out_data_reg.record_offset   <= s1_rec_reg.record_offset;
            out_data_reg.packet_number   <= s1_rec_reg.packet_number;
            out_data_reg.format_version  <= s1_rec_reg.format_version;
            out_data_reg.unknown_version <= s1_rec_reg.unknown_version;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Input is held off only while both stages are full and blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipe");

    // A record produced by an accepted byte lands in the record register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && rec_valid |=> s1_valid_reg)
        else $error("record transaction lost");

    // Every result starts in the payload area
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.record_offset >= FIRST_RECORD_BYTE)
        else $error("result with header offset");

endmodule

`default_nettype wire

// ----- rtl/core/pspp_parser.sv -----
// Byte-level packet parser: header capture and record assembly.
// Depends on pspp_pkg. Produces at most one record per accepted byte,
// combinationally from the current state and the incoming byte.
`default_nettype none

module pspp_parser
    import pspp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire in_t  in_data,
    output logic      rec_valid,
    output rec_t      rec
);

    // Byte slots of a record, counted as if the time count had three bytes
    localparam logic [2:0] SLOT_TIME_HI  = 3'd1;
    localparam logic [2:0] SLOT_TIME_MID = 3'd2;
    localparam logic [2:0] SLOT_TIME_LO  = 3'd3;
    localparam logic [2:0] SLOT_PRES_HI  = 3'd4;
    localparam logic [2:0] SLOT_PRES_MID = 3'd5;
    localparam logic [2:0] SLOT_PRES_LO  = 3'd6;

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [3:0]          id_reg, id_next;
    logic [3:0]          version_reg, version_next;
    logic [OFFSET_W-1:0] length_reg, length_next;
    logic [31:0]         base_reg, base_next;
    logic [2:0]          pos_reg, pos_next;
    logic [23:0]         tc_reg, tc_next;
    logic [23:0]         pb_reg, pb_next;
    logic [OFFSET_W-1:0] start_reg, start_next;

    logic       long_time;
    logic [2:0] slot;
    logic       open_new;
    logic       complete;
    logic [7:0] b;

    assign b         = in_data.packet_byte;
    assign long_time = (version_reg == VERSION_LONG_TIME);
    // Slot of this byte; a fresh record starts with position zero
    assign slot      = pos_reg + (long_time ? 3'd1 : 3'd2);
    assign open_new  = (pos_reg == 3'd0) && (offset_reg >= FIRST_RECORD_BYTE)
                       && (({1'b0, offset_reg} + 13'd1) < {1'b0, length_reg});

    // Next state and record assembly
    always_comb
    begin
        offset_next  = offset_reg;
        id_next      = id_reg;
        version_next = version_reg;
        length_next  = length_reg;
        base_next    = base_reg;
        pos_next     = pos_reg;
        tc_next      = tc_reg;
        pb_next      = pb_reg;
        start_next   = start_reg;
        complete     = 1'b0;

        if (pos_reg != 3'd0 || open_new)
        begin
            if (open_new)
            begin
                start_next = offset_reg;
                tc_next    = 24'd0;
                pb_next    = 24'd0;
            end
            // Drop the byte into its fixed place
            case (slot)
                SLOT_TIME_HI:  tc_next[23:16] = tc_next[23:16] | b;
                SLOT_TIME_MID: tc_next[15:8]  = tc_next[15:8]  | b;
                SLOT_TIME_LO:  tc_next[7:0]   = tc_next[7:0]   | b;
                SLOT_PRES_HI:  pb_next[23:16] = pb_next[23:16] | b;
                SLOT_PRES_MID: pb_next[15:8]  = pb_next[15:8]  | b;
                SLOT_PRES_LO:  pb_next[7:0]   = pb_next[7:0]   | b;
                default: ;
            endcase
            complete = (slot == SLOT_PRES_LO);
            pos_next = complete ? 3'd0 : pos_reg + 3'd1;
        end
        else if (offset_reg < FIRST_RECORD_BYTE)
        begin
            // Capture header fields
            unique case (offset_reg) inside
                HDR_ID:      id_next = b[3:0];
                HDR_VER_LEN:
                begin
                    version_next = b[7:4];
                    length_next  = {b[3:0], length_reg[7:0]};
                end
                HDR_LEN_LO:  length_next = {length_reg[11:8], b};
                HDR_TIME_B3: base_next[31:24] = b;
                HDR_TIME_B2: base_next[23:16] = b;
                HDR_TIME_B1: base_next[15:8]  = b;
                HDR_TIME_B0: base_next[7:0]   = b;
                default: ;
            endcase
        end

        rec_valid = accept && (complete || (in_data.last_byte && pos_next != 3'd0));

        rec.status          = !complete;
        rec.time_seconds    = {1'b0, base_next} + {9'd0, tc_next};
        rec.phase           = pb_next[23:20];
        rec.pressure_count  = pb_next[19:0];
        rec.record_offset   = start_next;
        rec.packet_number   = id_next;
        rec.format_version  = version_next;
        rec.unknown_version = (version_next > VERSION_LONG_TIME);

        // Packet end clears everything, otherwise advance the offset up to OFFSET_MAX
        if (in_data.last_byte)
        begin
            offset_next  = '0;
            id_next      = '0;
            version_next = '0;
            length_next  = '0;
            base_next    = '0;
            pos_next     = '0;
            tc_next      = '0;
            pb_next      = '0;
            start_next   = '0;
        end
        else if (offset_reg < OFFSET_MAX)
        begin
            offset_next = offset_reg + 12'd1;
        end
    end

    // Hold state until a transaction is accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            id_reg      <= '0;
            version_reg <= '0;
            length_reg  <= '0;
            base_reg    <= '0;
            pos_reg     <= '0;
            tc_reg      <= '0;
            pb_reg      <= '0;
            start_reg   <= '0;
        end
        else if (accept)
        begin
            offset_reg  <= offset_next;
            id_reg      <= id_next;
            version_reg <= version_next;
            length_reg  <= length_next;
            base_reg    <= base_next;
            pos_reg     <= pos_next;
            tc_reg      <= tc_next;
            pb_reg      <= pb_next;
            start_reg   <= start_next;
        end
    end

    // An open record never reaches past its final slot
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < SLOT_PRES_LO)
        else $error("record position out of range");

    // A packet end leaves the parser at offset zero with no record open
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last_byte |=> offset_reg == '0 && pos_reg == 3'd0)
        else $error("state not cleared after packet end");

    // Records only start in the payload area
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 3'd0 |-> start_reg >= FIRST_RECORD_BYTE)
        else $error("record opened inside header");

endmodule

`default_nettype wire
